// ===== sv/cce_pkg.sv =====
`default_nettype none
package cce_pkg;

  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;

  // mode codes
  localparam logic [2:0] MODE_SUM8   = 3'd0;
  localparam logic [2:0] MODE_XOR8   = 3'd1;
  localparam logic [2:0] MODE_CRC8   = 3'd2;
  localparam logic [2:0] MODE_CCITT  = 3'd3;
  localparam logic [2:0] MODE_MODBUS = 3'd4;
  localparam logic [2:0] MODE_CRC32  = 3'd5;

  // register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLYNOMIAL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INIT       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FINAL_XOR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REFIN      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REFOUT     = 3'd5;

  // standard values
  localparam logic [7:0]  CRC8_POLY    = 8'h07;
  localparam logic [15:0] CCITT_POLY   = 16'h1021;
  localparam logic [15:0] CCITT_INIT   = 16'hFFFF;
  localparam logic [15:0] MODBUS_INIT  = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY  = 16'hA001;
  localparam logic [31:0] CRC32_POLY   = 32'h04C11DB7;
  localparam logic [31:0] CRC32_ONES   = 32'hFFFFFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] polynomial;
    logic [31:0] initial_value;
    logic [31:0] final_xor;
    logic        reflect_input;
    logic        reflect_output;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/cce_byte_if.sv =====
`default_nettype none
interface cce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/cce_result_if.sv =====
`default_nettype none
interface cce_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source(output valid, output checksum, input ready);
  modport sink(input valid, input checksum, output ready);
endinterface
`default_nettype wire

// ===== sv/cce_fold.sv =====
`default_nettype none
module cce_fold (
  input  var cce_pkg::cfg_t cfg,
  input  wire logic [31:0]  running,
  input  wire logic         first,
  input  wire logic [7:0]   data_byte,
  output logic [31:0]       running_next,
  output logic [31:0]       checksum
);

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = v[15-i];
    return r;
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    return r;
  endfunction

  logic [31:0] start;
  logic        poly_zero;
  logic        crc32_refin;
  logic        crc32_refout;
  logic [7:0]  p8;
  logic [15:0] p16;
  logic [31:0] p32;
  logic [7:0]  c8;
  logic [15:0] c16;
  logic [15:0] cmb;
  logic [31:0] c32;
  logic [31:0] fx32;

  assign poly_zero    = (cfg.polynomial == 32'd0);
  // crc32 with both flags clear runs fully reflected
  assign crc32_refin  = (cfg.reflect_input | cfg.reflect_output) ? cfg.reflect_input  : 1'b1;
  assign crc32_refout = (cfg.reflect_input | cfg.reflect_output) ? cfg.reflect_output : 1'b1;
  assign p8   = poly_zero ? cce_pkg::CRC8_POLY  : cfg.polynomial[7:0];
  assign p16  = poly_zero ? cce_pkg::CCITT_POLY : cfg.polynomial[15:0];
  assign p32  = poly_zero ? cce_pkg::CRC32_POLY : cfg.polynomial;
  assign fx32 = (cfg.final_xor == 32'd0) ? cce_pkg::CRC32_ONES : cfg.final_xor;

  // start value on the first byte of a message
  always_comb begin
    start = running;
    if (first) begin
      case (cfg.mode)
        cce_pkg::MODE_CRC8:   start = {24'd0, cfg.initial_value[7:0]};
        cce_pkg::MODE_CCITT:  start = (cfg.initial_value == 32'd0) ?
                                      {16'd0, cce_pkg::CCITT_INIT} :
                                      {16'd0, cfg.initial_value[15:0]};
        cce_pkg::MODE_MODBUS: start = {16'd0, cce_pkg::MODBUS_INIT};
        cce_pkg::MODE_CRC32:  start = (cfg.initial_value == 32'd0) ?
                                      cce_pkg::CRC32_ONES : cfg.initial_value;
        default:              start = 32'd0;
      endcase
    end
  end

  // unrolled eight-bit updates
  always_comb begin
    c8 = start[7:0] ^ (cfg.reflect_input ? rev8(data_byte) : data_byte);
    for (int i = 0; i < 8; i++) c8 = c8[7] ? ({c8[6:0], 1'b0} ^ p8) : {c8[6:0], 1'b0};

    c16 = start[15:0] ^ {(cfg.reflect_input ? rev8(data_byte) : data_byte), 8'd0};
    for (int i = 0; i < 8; i++) c16 = c16[15] ? ({c16[14:0], 1'b0} ^ p16) : {c16[14:0], 1'b0};

    cmb = start[15:0] ^ {8'd0, data_byte};
    for (int i = 0; i < 8; i++)
      cmb = cmb[0] ? ({1'b0, cmb[15:1]} ^ cce_pkg::MODBUS_POLY) : {1'b0, cmb[15:1]};

    c32 = start ^ {(crc32_refin ? rev8(data_byte) : data_byte), 24'd0};
    for (int i = 0; i < 8; i++) c32 = c32[31] ? ({c32[30:0], 1'b0} ^ p32) : {c32[30:0], 1'b0};
  end

  always_comb begin
    case (cfg.mode)
      cce_pkg::MODE_SUM8: begin
        running_next = {24'd0, start[7:0] + data_byte};
        checksum     = running_next;
      end
      cce_pkg::MODE_XOR8: begin
        running_next = {24'd0, start[7:0] ^ data_byte};
        checksum     = running_next;
      end
      cce_pkg::MODE_CRC8: begin
        running_next = {24'd0, c8};
        checksum     = {24'd0, (cfg.reflect_output ? rev8(c8) : c8) ^ cfg.final_xor[7:0]};
      end
      cce_pkg::MODE_CCITT: begin
        running_next = {16'd0, c16};
        checksum     = {16'd0, (cfg.reflect_output ? rev16(c16) : c16) ^ cfg.final_xor[15:0]};
      end
      cce_pkg::MODE_MODBUS: begin
        running_next = {16'd0, cmb};
        checksum     = running_next;
      end
      cce_pkg::MODE_CRC32: begin
        running_next = c32;
        checksum     = (crc32_refout ? rev32(c32) : c32) ^ fx32;
      end
      default: begin
        running_next = start;
        checksum     = 32'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/configurable_checksum_engine_top.sv =====
// flow: an accepted byte is registered in the input stage and folded into the running
//   register as it advances; on a last byte the checksum is loaded into the result register
// throughput: one byte per cycle, set by the combinational eight-bit fold of the
//   running register; a last byte stalls only while the result register is held
// reset: synchronous active-high rst clears the configuration, the running checksum and
//   every valid flag, which empties the pipe; byte and checksum data registers keep contents
`default_nettype none
module configurable_checksum_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cce_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  cce_byte_if.sink                         msg,
  cce_result_if.source                     result
);

  // configuration registers
  cce_pkg::cfg_t cfg;
  logic [cce_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_write;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;

  // running checksum state
  logic [31:0] running;
  logic        in_message;

  // result register
  logic        out_valid;
  logic [31:0] out_checksum;

  logic [31:0] running_next;
  logic [31:0] checksum_next;
  logic        advance;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[cce_pkg::ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        cce_pkg::REG_MODE:       cfg.mode           <= pwdata[2:0];
        cce_pkg::REG_POLYNOMIAL: cfg.polynomial     <= pwdata;
        cce_pkg::REG_INIT:       cfg.initial_value  <= pwdata;
        cce_pkg::REG_FINAL_XOR:  cfg.final_xor      <= pwdata;
        cce_pkg::REG_REFIN:      cfg.reflect_input  <= pwdata[0];
        cce_pkg::REG_REFOUT:     cfg.reflect_output <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      cce_pkg::REG_MODE:       prdata = {29'd0, cfg.mode};
      cce_pkg::REG_POLYNOMIAL: prdata = cfg.polynomial;
      cce_pkg::REG_INIT:       prdata = cfg.initial_value;
      cce_pkg::REG_FINAL_XOR:  prdata = cfg.final_xor;
      cce_pkg::REG_REFIN:      prdata = {31'd0, cfg.reflect_input};
      cce_pkg::REG_REFOUT:     prdata = {31'd0, cfg.reflect_output};
      default:                 prdata = 32'd0;
    endcase
  end

  // a non-last byte never needs the result register, so it always moves on;
  // a last byte waits until the result register is free or being emptied
  assign advance   = s1_valid & (~s1_last | ~out_valid | result.ready);
  assign msg.ready = ~s1_valid | advance;

  cce_fold u_fold (
    .cfg          (cfg),
    .running      (running),
    .first        (~in_message),
    .data_byte    (s1_data),
    .running_next (running_next),
    .checksum     (checksum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      running    <= 32'd0;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (msg.ready) s1_valid <= msg.valid;
      if (advance) begin
        running    <= running_next;
        in_message <= ~s1_last;
      end
      if (out_valid & result.ready) out_valid <= 1'b0;
      // a new result may land in the same cycle the old beat leaves
      if (advance & s1_last) out_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (msg.ready & msg.valid) begin
      s1_data <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
    if (advance & s1_last) out_checksum <= checksum_next;
  end

  assign result.valid    = out_valid;
  assign result.checksum = out_checksum;

  // a waiting result is never overwritten by a finishing message
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_last && out_valid && !result.ready))
    else $error("result register overwritten");

  // finishing a message closes it and presents a result beat
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (!in_message && out_valid))
    else $error("message end not handled");

  // an accepted byte is held in the input stage
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.ready) |=> s1_valid)
    else $error("accepted byte lost");

endmodule
`default_nettype wire
